@@ rtl/u8u2_pkg.sv @@
`default_nettype none

package u8u2_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CONT_MIN  = 8'h80;
    localparam logic [7:0] LEAD2_MIN = 8'hC0;
    localparam logic [7:0] LEAD3_MIN = 8'hE0;

    // Results produced by one request: up to three code units and a terminator.
    typedef struct packed {
        logic [2:0]       cnt;
        logic             term;
        logic [3:0][15:0] unit;
    } t_bundle;

    typedef struct packed {
        t_bundle    bun;
        logic [7:0] h0;
        logic [7:0] h1;
        logic [1:0] hc;
        logic       done;
    } t_step;

    function automatic logic [15:0] fallback(input logic [7:0] b);
        return {9'd0, b[6:0]};
    endfunction

    function automatic t_step decode(input logic [7:0] h0, input logic [7:0] h1,
                                     input logic [1:0] hc, input logic [7:0] b,
                                     input logic last);
        t_step       r;
        logic [23:0] win;
        logic [1:0]  n;
        logic [1:0]  used;
        logic        stop;
        logic        zhit;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [15:0] u;
        logic [2:0]  k;
        r    = '0;
        win  = {8'h00, h1, h0};
        n    = (hc == 2'd3) ? 2'd2 : hc;
        case (n)
            2'd0:    win[7:0]   = b;
            2'd1:    win[15:8]  = b;
            default: win[23:16] = b;
        endcase
        n    = n + 2'd1;
        k    = 3'd0;
        stop = 1'b0;
        zhit = 1'b0;
        for (int it = 0; it < 3; it++) begin
            b0   = win[7:0];
            b1   = win[15:8];
            b2   = win[23:16];
            used = 2'd0;
            u    = 16'd0;
            if (!stop && n != 2'd0) begin
                if (b0 == 8'h00) begin
                    r.bun.unit[k[1:0]] = 16'd0;
                    r.bun.term = 1'b1;
                    k    = k + 3'd1;
                    zhit = 1'b1;
                    n    = 2'd0;
                    stop = 1'b1;
                end else if (b0 < CONT_MIN) begin
                    u    = {8'd0, b0};
                    used = 2'd1;
                end else if (b0 >= LEAD2_MIN && b0 < LEAD3_MIN) begin
                    if (n >= 2'd2) begin
                        if (b1 >= CONT_MIN) begin
                            u    = {5'd0, b0[4:0], b1[5:0]};
                            used = 2'd2;
                        end else begin
                            u    = fallback(b0);
                            used = 2'd1;
                        end
                    end else if (last) begin
                        u    = fallback(b0);
                        used = 2'd1;
                    end
                end else if (b0 >= LEAD3_MIN) begin
                    if (n >= 2'd2 && b1 < CONT_MIN) begin
                        u    = fallback(b0);
                        used = 2'd1;
                    end else if (n == 2'd3) begin
                        if (b2 >= CONT_MIN) begin
                            u    = {b0[3:0], b1[5:0], b2[5:0]};
                            used = 2'd3;
                        end else begin
                            u    = fallback(b0);
                            used = 2'd1;
                        end
                    end else if (last) begin
                        u    = fallback(b0);
                        used = 2'd1;
                    end
                end else begin
                    u    = fallback(b0);
                    used = 2'd1;
                end
                if (!zhit) begin
                    if (used == 2'd0) begin
                        stop = 1'b1;
                    end else begin
                        r.bun.unit[k[1:0]] = u;
                        k   = k + 3'd1;
                        win = win >> {used, 3'b000};
                        n   = n - used;
                    end
                end
            end
        end
        if (last && !zhit) begin
            r.bun.unit[k[1:0]] = 16'd0;
            r.bun.term = 1'b1;
            k = k + 3'd1;
            n = 2'd0;
        end
        r.done    = zhit || last;
        r.bun.cnt = k;
        r.hc      = (n == 2'd3) ? 2'd2 : n;
        r.h0      = (r.hc != 2'd0) ? win[7:0] : 8'h00;
        r.h1      = (r.hc == 2'd2) ? win[15:8] : 8'h00;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/utf8_to_ucs2_decoder_unit.sv @@
`default_nettype none

// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_ready  | i_in_byte[7:0], i_last_byte
// output   | out       | o_valid / i_ready  | o_code_unit[15:0], o_end_mark
//
// One byte request is taken per cycle while the four-entry result queue has room.
// A byte that completes several units delivers them one per cycle from the back end
// while i_ready is high. When the queue and the output stage are empty, the first
// result of an accepted byte is written into the queue, then loaded into the output
// register before it is shown.
// Reset is synchronous and active low; it clears held bytes, the queue and the output.
// Output stalls fill the queue and then drop o_ready; bytes after the terminator are
// accepted and discarded.

module utf8_to_ucs2_decoder_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_last_byte,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [15:0] o_code_unit,
    output logic        o_end_mark
);

    u8u2_pkg::t_bundle push_data;
    u8u2_pkg::t_bundle head_data;
    logic              push;
    logic              full;
    logic              empty;
    logic              pop;

    u8u2_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_in_byte   (i_in_byte),
        .i_last_byte (i_last_byte),
        .i_full      (full),
        .o_push      (push),
        .o_bundle    (push_data)
    );

    u8u2_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (head_data)
    );

    u8u2_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_data      (head_data),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_code_unit (o_code_unit),
        .o_end_mark  (o_end_mark)
    );

endmodule

`default_nettype wire

@@ rtl/u8u2_front.sv @@
`default_nettype none

module u8u2_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_in_byte,
    input  wire                 i_last_byte,
    input  wire                 i_full,
    output logic                o_push,
    output u8u2_pkg::t_bundle   o_bundle
);

    logic [7:0]      r_h0, n_h0;
    logic [7:0]      r_h1, n_h1;
    logic [1:0]      r_hc, n_hc;
    logic            r_done, n_done;
    logic            accept;
    u8u2_pkg::t_step step;

    always_comb begin
        step     = u8u2_pkg::decode(r_h0, r_h1, r_hc, i_in_byte, i_last_byte);
        o_ready  = !i_full;
        accept   = i_valid && o_ready;
        o_push   = accept && !r_done && (step.bun.cnt != 3'd0);
        o_bundle = step.bun;
        n_h0     = r_h0;
        n_h1     = r_h1;
        n_hc     = r_hc;
        n_done   = r_done;
        if (accept && !r_done) begin
            n_h0   = step.h0;
            n_h1   = step.h1;
            n_hc   = step.hc;
            n_done = step.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h0   <= 8'h00;
            r_h1   <= 8'h00;
            r_hc   <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_h0   <= n_h0;
            r_h1   <= n_h1;
            r_hc   <= n_hc;
            r_done <= n_done;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8u2_queue.sv @@
`default_nettype none

module u8u2_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    output logic                o_full,
    input  u8u2_pkg::t_bundle   i_data,
    input  wire                 i_pop,
    output logic                o_empty,
    output u8u2_pkg::t_bundle   o_data
);

    u8u2_pkg::t_bundle                r_mem [u8u2_pkg::QDEPTH];
    logic [u8u2_pkg::QPTR_W-1:0]      r_wr, n_wr;
    logic [u8u2_pkg::QPTR_W-1:0]      r_rd, n_rd;
    logic [u8u2_pkg::QCNT_W-1:0]      r_cnt, n_cnt;
    logic                             do_pop;

    always_comb begin
        o_full  = (r_cnt == u8u2_pkg::QCNT_W'(u8u2_pkg::QDEPTH));
        o_empty = (r_cnt == '0);
        o_data  = r_mem[r_rd];
        do_pop  = i_pop && !o_empty;
        n_wr    = i_push ? r_wr + 1'b1 : r_wr;
        n_rd    = do_pop ? r_rd + 1'b1 : r_rd;
        n_cnt   = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

`default_nettype wire

@@ rtl/u8u2_back.sv @@
`default_nettype none

module u8u2_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_empty,
    input  u8u2_pkg::t_bundle   i_data,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [15:0]         o_code_unit,
    output logic                o_end_mark
);

    u8u2_pkg::t_bundle r_cur, n_cur;
    logic              r_valid, n_valid;
    logic [1:0]        r_idx, n_idx;
    logic              take;
    logic              last_item;

    always_comb begin
        o_valid     = r_valid;
        o_code_unit = r_cur.unit[r_idx];
        last_item   = ({1'b0, r_idx} == r_cur.cnt - 3'd1);
        o_end_mark  = r_cur.term && last_item;
        take        = r_valid && i_ready;
        o_pop       = (!r_valid || (take && last_item)) && !i_empty;
        n_cur       = r_cur;
        n_valid     = r_valid;
        n_idx       = r_idx;
        if (o_pop) begin
            n_cur   = i_data;
            n_valid = 1'b1;
            n_idx   = 2'd0;
        end else if (take && last_item) begin
            n_valid = 1'b0;
        end else if (take) begin
            n_idx   = r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    a_end_is_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_mark |-> o_code_unit == 16'd0)
        else $error("terminator carries a non-zero code unit");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < r_cur.cnt))
        else $error("result index beyond bundle size");

    a_nothing_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && o_end_mark |=> !o_valid)
        else $error("result delivered after terminator");

endmodule

`default_nettype wire
